// ----- rtl/pictl_pkg.sv -----
// Shared widths, constants and state codes of the PI controller.
package pictl_pkg;

  localparam int SAMPLE_W = 10;
  localparam int KP_W     = 10;
  localparam int KI_W     = 24;
  localparam int CFG_W    = 24;
  localparam int ERR_W    = 11;
  localparam int GAIN_W   = 22;
  localparam int MCAND_W  = 23;
  localparam int ACC_W    = 24;
  localparam int OUT_W    = 24;
  localparam int SUM_W    = 42;
  localparam int DUTY_W   = 8;
  localparam int CNT_W    = 5;
  localparam int FRAC_W   = 16;

  localparam logic CFG_KP = 1'b0;
  localparam logic CFG_KI = 1'b1;

  localparam logic [KP_W-1:0] KP_RESET = KP_W'(500);
  localparam logic [KI_W-1:0] KI_RESET = KI_W'(8389);

  localparam logic signed [SUM_W-1:0] OUT_UPPER = SUM_W'(126) <<< FRAC_W;
  localparam logic signed [SUM_W-1:0] OUT_LOWER = -(SUM_W'(127) <<< FRAC_W);
  localparam logic [DUTY_W-1:0] DUTY_OFFSET = DUTY_W'(127);

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [ST_W-1:0] ST_GAIN  = 3'd1;
  localparam logic [ST_W-1:0] ST_LOADI = 3'd2;
  localparam logic [ST_W-1:0] ST_INT   = 3'd3;
  localparam logic [ST_W-1:0] ST_FIN   = 3'd4;
  localparam logic [ST_W-1:0] ST_DONE  = 3'd5;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [DUTY_W-1:0] duty_t;

endpackage

// ----- rtl/pictl_in_if.sv -----
// Input channel carrying one command and one feedback sample.
interface pictl_in_if import pictl_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t command_sample;
  sample_t feedback_sample;

  modport source (output valid, output command_sample, output feedback_sample, input ready);
  modport sink (input valid, input command_sample, input feedback_sample, output ready);
endinterface

// ----- rtl/pictl_out_if.sv -----
// Result channel carrying the duty value and clamp flag.
interface pictl_out_if import pictl_pkg::*; ();
  logic  valid;
  logic  ready;
  duty_t duty;
  logic  clamped;

  modport source (output valid, output duty, output clamped, input ready);
  modport sink (input valid, input duty, input clamped, output ready);
endinterface

// ----- rtl/pi_controller_tustin_clamped_unit.sv -----
// Tustin PI position controller with a bit-serial multiplier and output clamp.
//
// Usage:
//   in_chan  : valid/ready transaction of command_sample and feedback_sample.
//   out_chan : valid/ready transaction of duty (0..253) and clamped flag.
//   cfg_*    : write proportional_gain (index 0) or half_integral_coeff
//              (index 1) while the block is idle; no read-back.
// Each transaction runs through one shift-add unit that retires one
// multiplier bit per cycle: first error times gain, then the integral
// coefficient product, plus setup and final sum/clamp steps.
// A new input is taken only once the block is back in idle, after the
// previous result has moved to the output register.
// The result sits in an output register, so the next input is accepted
// while a result still waits; if the receiver stalls until the next result
// is done, the block holds it internally until the output register frees.
// Reset (rst_n low, synchronous) restores the default gains, clears the
// previous gain term and previous output, and drops any pending result.
module pi_controller_tustin_clamped_unit import pictl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_idx,
  input  logic [CFG_W-1:0] cfg_data,
  pictl_in_if.sink         in_chan,
  pictl_out_if.source      out_chan
);

  logic [ST_W-1:0]           state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [KP_W-1:0]           kp_r;
  logic [KI_W-1:0]           ki_r;
  logic signed [MCAND_W-1:0] mcand_r, mcand_nxt;
  logic [KI_W-1:0]           mplier_r, mplier_nxt;
  logic signed [ACC_W-1:0]   hi_r, hi_nxt;
  logic [ACC_W-1:0]          lo_r, lo_nxt;
  logic signed [GAIN_W-1:0]  gain_r, gain_nxt;
  logic signed [GAIN_W-1:0]  prev_gain_r, prev_gain_nxt;
  logic signed [OUT_W-1:0]   prev_out_r, prev_out_nxt;
  logic signed [SUM_W-1:0]   part_r, part_nxt;
  duty_t                     res_duty_r, res_duty_nxt;
  logic                      res_clip_r, res_clip_nxt;
  logic                      out_valid_r, out_valid_nxt;
  duty_t                     out_duty_r, out_duty_nxt;
  logic                      out_clip_r, out_clip_nxt;

  logic signed [ACC_W:0]     step_sum;
  logic signed [GAIN_W-1:0]  gain_w;
  logic signed [MCAND_W-1:0] gsum_w, gdiff_w;
  logic signed [SUM_W-1:0]   o_full;
  logic signed [OUT_W-1:0]   o_clamp;
  logic signed [DUTY_W-1:0]  whole;
  logic                      clip_w;
  logic                      accept_in;
  logic                      out_free;

  assign in_chan.ready    = (state_r == ST_IDLE);
  assign accept_in        = in_chan.valid && in_chan.ready;
  assign out_free         = !out_valid_r || out_chan.ready;
  assign out_chan.valid   = out_valid_r;
  assign out_chan.duty    = out_duty_r;
  assign out_chan.clamped = out_clip_r;

  assign step_sum = (ACC_W+1)'(hi_r) + (mplier_r[0] ? (ACC_W+1)'(mcand_r) : '0);
  assign gain_w   = {hi_r[ERR_W:0], lo_r[ACC_W-1 -: KP_W]};
  assign gsum_w   = MCAND_W'(gain_w) + MCAND_W'(prev_gain_r);
  assign gdiff_w  = MCAND_W'(gain_w) - MCAND_W'(prev_gain_r);
  assign o_full   = part_r + SUM_W'($signed({hi_r, lo_r[ACC_W-1:8]}));

  always_comb begin
    clip_w  = 1'b0;
    o_clamp = o_full[OUT_W-1:0];
    if (o_full > OUT_UPPER) begin
      clip_w  = 1'b1;
      o_clamp = OUT_UPPER[OUT_W-1:0];
    end else if (o_full < OUT_LOWER) begin
      clip_w  = 1'b1;
      o_clamp = OUT_LOWER[OUT_W-1:0];
    end
    whole = o_clamp[OUT_W-1:FRAC_W] +
            DUTY_W'(o_clamp[OUT_W-1] && (o_clamp[FRAC_W-1:0] != '0));
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    gain_nxt      = gain_r;
    prev_gain_nxt = prev_gain_r;
    prev_out_nxt  = prev_out_r;
    part_nxt      = part_r;
    res_duty_nxt  = res_duty_r;
    res_clip_nxt  = res_clip_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_duty_nxt  = out_duty_r;
    out_clip_nxt  = out_clip_r;
    unique case (state_r) inside
      ST_IDLE: begin
        if (accept_in) begin
          mcand_nxt  = MCAND_W'($signed({1'b0, in_chan.command_sample}) -
                                $signed({1'b0, in_chan.feedback_sample}));
          mplier_nxt = KI_W'(kp_r);
          hi_nxt     = '0;
          lo_nxt     = '0;
          cnt_nxt    = CNT_W'(KP_W - 1);
          state_nxt  = ST_GAIN;
        end
      end
      ST_GAIN, ST_INT: begin
        hi_nxt     = step_sum[ACC_W:1];
        lo_nxt     = {step_sum[0], lo_r[ACC_W-1:1]};
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = (state_r == ST_GAIN) ? ST_LOADI : ST_FIN;
        end
      end
      ST_LOADI: begin
        gain_nxt   = gain_w;
        part_nxt   = SUM_W'(prev_out_r) + (SUM_W'(gdiff_w) <<< FRAC_W);
        mcand_nxt  = gsum_w;
        mplier_nxt = ki_r;
        hi_nxt     = '0;
        lo_nxt     = '0;
        cnt_nxt    = CNT_W'(KI_W - 1);
        state_nxt  = ST_INT;
      end
      ST_FIN: begin
        prev_gain_nxt = gain_r;
        prev_out_nxt  = o_clamp;
        res_duty_nxt  = duty_t'(whole) + DUTY_OFFSET;
        res_clip_nxt  = clip_w;
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_duty_nxt  = res_duty_r;
          out_clip_nxt  = res_clip_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      kp_r        <= KP_RESET;
      ki_r        <= KI_RESET;
      prev_gain_r <= '0;
      prev_out_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      prev_gain_r <= prev_gain_nxt;
      prev_out_r  <= prev_out_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_KP:  kp_r <= cfg_data[KP_W-1:0];
          CFG_KI:  ki_r <= cfg_data[KI_W-1:0];
          default: kp_r <= kp_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    mcand_r    <= mcand_nxt;
    mplier_r   <= mplier_nxt;
    hi_r       <= hi_nxt;
    lo_r       <= lo_nxt;
    gain_r     <= gain_nxt;
    part_r     <= part_nxt;
    res_duty_r <= res_duty_nxt;
    res_clip_r <= res_clip_nxt;
    out_duty_r <= out_duty_nxt;
    out_clip_r <= out_clip_nxt;
  end

endmodule
